[rtl/mbse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Marker byte stuffing encoder package
// Shared constants and request/result types for the stuffing encoder.
// ----------------------------------------------------------------------------
package mbse_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned ADDR_W = 6;

  localparam logic [CNT_W-1:0]  MAX_PAYLOAD  = 7'd63;
  localparam logic [BYTE_W-1:0] NO_MARKER    = 8'hFF;
  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'd126;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_overhead;
    logic              last_out;
    logic              too_long;
  } res_t;

endpackage

[rtl/marker_byte_stuffing_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Marker byte stuffing encoder core
// Stores a payload, links marker bytes in place, then emits the overhead
// byte and the stuffed payload, or one error result on overflow.
// ----------------------------------------------------------------------------
// Load: one RAM write per byte, plus a second write for a marker that follows an
// earlier marker; the final marker slot is zeroed after a non-marker last byte.
// Drain: overhead byte the cycle after load ends, then one byte per cycle
// from the RAM read port.
// Reset clears counters and marker tracking at once; the payload RAM is not
// cleared. Results are strobed once and cannot be stalled.
module marker_byte_stuffing_encoder_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  mbse_pkg::req_t         req_i,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  output logic                   res_strobe_o,
  output mbse_pkg::res_t         res_o
);
  import mbse_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIX   = 3'd1;
  localparam logic [2:0] ST_OVH   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [BYTE_W-1:0] marker_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] first_q, first_d;
  logic [BYTE_W-1:0] prev_q, prev_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;
  logic [ADDR_W-1:0] fix_addr_q, fix_addr_d;
  logic [BYTE_W-1:0] fix_data_q, fix_data_d;
  logic [CNT_W-1:0]  drain_q, drain_d;
  logic [BYTE_W-1:0] rdata_q;

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data;

  logic              accept, full, is_mk;
  logic [CNT_W-1:0]  drain_nxt;

  assign accept    = start && (state_q == ST_IDLE);
  assign full      = ovf_q || (count_q >= MAX_PAYLOAD);
  assign is_mk     = (req_i.data_byte == marker_q);
  assign drain_nxt = drain_q + 7'd1;
  assign busy      = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    first_d    = first_q;
    prev_d     = prev_q;
    ovf_d      = ovf_q;
    last_d     = last_q;
    fix_addr_d = fix_addr_q;
    fix_data_d = fix_data_q;
    drain_d    = drain_q;
    wr_en      = 1'b0;
    wr_addr    = count_q[ADDR_W-1:0];
    wr_data    = req_i.data_byte;
    rd_en      = 1'b0;
    rd_addr    = '0;
    res_strobe_o = 1'b0;
    res_o      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
            if (req_i.last_byte) begin
              state_d = ST_ERR;
              count_d = '0;
              first_d = NO_MARKER;
              prev_d  = NO_MARKER;
              ovf_d   = 1'b0;
              last_d  = 1'b0;
            end
          end else begin
            wr_en   = 1'b1;
            // a final marker on the last byte links to nothing
            wr_data = (is_mk && req_i.last_byte) ? '0 : req_i.data_byte;
            count_d = count_q + 7'd1;
            last_d  = req_i.last_byte;
            state_d = req_i.last_byte ? ST_OVH : ST_IDLE;
            if (is_mk) begin
              prev_d = {1'b0, count_q};
              if (prev_q == NO_MARKER) begin
                first_d = {1'b0, count_q};
              end else begin
                fix_addr_d = prev_q[ADDR_W-1:0];
                fix_data_d = {1'b0, count_q} - prev_q;
                state_d    = ST_FIX;
              end
            end else if (req_i.last_byte && (prev_q != NO_MARKER)) begin
              fix_addr_d = prev_q[ADDR_W-1:0];
              fix_data_d = '0;
              state_d    = ST_FIX;
            end
          end
        end
      end
      ST_FIX: begin
        wr_en   = 1'b1;
        wr_addr = fix_addr_q;
        wr_data = fix_data_q;
        state_d = last_q ? ST_OVH : ST_IDLE;
      end
      ST_OVH: begin
        res_strobe_o      = 1'b1;
        res_o.out_byte    = first_q;
        res_o.is_overhead = 1'b1;
        res_o.last_out    = (count_q == '0);
        rd_en   = 1'b1;
        rd_addr = '0;
        drain_d = '0;
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        res_strobe_o   = 1'b1;
        res_o.out_byte = rdata_q;
        res_o.last_out = (drain_nxt == count_q);
        if (drain_nxt == count_q) begin
          state_d = ST_IDLE;
          count_d = '0;
          first_d = NO_MARKER;
          prev_d  = NO_MARKER;
          ovf_d   = 1'b0;
          last_d  = 1'b0;
        end else begin
          // prefetch the next stored byte
          rd_en   = 1'b1;
          rd_addr = drain_nxt[ADDR_W-1:0];
          drain_d = drain_nxt;
        end
      end
      ST_ERR: begin
        res_strobe_o   = 1'b1;
        res_o.last_out = 1'b1;
        res_o.too_long = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      marker_q <= MARKER_RESET;
      count_q  <= '0;
      first_q  <= NO_MARKER;
      prev_q   <= NO_MARKER;
      ovf_q    <= 1'b0;
      last_q   <= 1'b0;
      drain_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      first_q <= first_d;
      prev_q  <= prev_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
      drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fix_addr_q <= fix_addr_d;
    fix_data_q <= fix_data_d;
  end

  // payload RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.too_long |-> res_o.last_out && !res_o.is_overhead)
    else $error("error result not marked last");

  a_ovh_followed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.is_overhead |=> res_strobe_o && !res_o.is_overhead)
    else $error("overhead byte not followed by payload");

  a_drain_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.last_out |=> res_strobe_o)
    else $error("gap inside packet results");

  a_last_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.last_byte |=> busy)
    else $error("last request did not start output");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_PAYLOAD)
    else $error("byte count beyond capacity");

  a_no_write_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> !wr_en)
    else $error("RAM write during output");

endmodule
